// File: rtl/bpa_pkg.sv
package bpa_pkg;

	localparam int ADDR_W     = 32;
	localparam int CNT_W      = 12;
	localparam int PAGE_SHIFT = 12;
	localparam int WORD_W     = 32;
	localparam int WORD_SHIFT = 5;
	localparam int PIDX_W     = ADDR_W - PAGE_SHIFT;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_ALLOC = 2'd1,
		OP_FREE  = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_FULL       = 3'd1,
		ST_OUTSIDE    = 3'd2,
		ST_MISALIGNED = 3'd3,
		ST_NOT_USED   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_ALLOC_RD,
		S_ALLOC_CHK,
		S_ALLOC_WR,
		S_FREE_RD,
		S_FREE_CHK,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		RD_HINT,
		RD_PTR,
		RD_FREE
	} rd_sel_t;

	typedef struct packed {
		logic    capture;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    clr_wr;
		logic    ptr_inc;
		logic    alloc_full;
		logic    alloc_take;
		logic    alloc_wr;
		logic    free_fail;
		logic    free_wr;
		logic    free_miss;
		logic    load_out;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic at_end;
		logic has_free;
		logic free_ok;
		logic bit_used;
	} dp_stat_t;

endpackage

// File: rtl/bpa_ctrl.sv
module bpa_ctrl import bpa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  op_t      op,
	input  logic     out_busy,
	input  dp_stat_t stat,
	output logic     in_ready,
	output cmd_t     cmd
);

	state_t state_q;
	state_t state_nx;
	logic   clr_reply_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_reply_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == S_IDLE && in_valid) begin
				clr_reply_q <= (op == OP_CLEAR);
			end
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_CLEAR: begin
				if (stat.clr_last) begin
					state_nx = clr_reply_q ? S_DONE : S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					case (op)
						OP_CLEAR: state_nx = S_CLEAR;
						OP_ALLOC: state_nx = S_ALLOC_CHK;
						OP_FREE:  state_nx = S_FREE_RD;
						default:  state_nx = S_DONE;
					endcase
				end
			end
			S_ALLOC_RD:  state_nx = S_ALLOC_CHK;
			S_ALLOC_CHK: begin
				if (stat.at_end) begin
					state_nx = S_DONE;
				end else if (stat.has_free) begin
					state_nx = S_ALLOC_WR;
				end else begin
					state_nx = S_ALLOC_RD;
				end
			end
			S_ALLOC_WR: state_nx = S_DONE;
			S_FREE_RD:  state_nx = stat.free_ok ? S_FREE_CHK : S_DONE;
			S_FREE_CHK: state_nx = S_DONE;
			S_DONE: begin
				if (!out_busy) begin
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.rd_sel = RD_HINT;
		in_ready = 1'b0;
		case (state_q)
			S_CLEAR: cmd.clr_wr = 1'b1;
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.rd_en   = 1'b1;
				cmd.rd_sel  = RD_HINT;
				cmd.capture = in_valid;
			end
			S_ALLOC_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_PTR;
			end
			S_ALLOC_CHK: begin
				if (stat.at_end) begin
					cmd.alloc_full = 1'b1;
				end else if (stat.has_free) begin
					cmd.alloc_take = 1'b1;
				end else begin
					cmd.ptr_inc = 1'b1;
				end
			end
			S_ALLOC_WR: cmd.alloc_wr = 1'b1;
			S_FREE_RD: begin
				if (stat.free_ok) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_FREE;
				end else begin
					cmd.free_fail = 1'b1;
				end
			end
			S_FREE_CHK: begin
				if (stat.bit_used) begin
					cmd.free_wr = 1'b1;
				end else begin
					cmd.free_miss = 1'b1;
				end
			end
			S_DONE: cmd.load_out = !out_busy;
			default: cmd = '0;
		endcase
	end

endmodule

// File: rtl/bpa_dp.sv
module bpa_dp import bpa_pkg::*; #(
	parameter int PAGE_COUNT = 3584
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	input  logic [ADDR_W-1:0] base_page,
	input  logic [ADDR_W-1:0] free_address,
	output dp_stat_t          stat,
	output logic [ADDR_W-1:0] page_address,
	output status_t           status,
	output logic [CNT_W-1:0]  used_count,
	output logic [CNT_W-1:0]  free_count
);

	localparam int NWORDS = (PAGE_COUNT + WORD_W - 1) / WORD_W;
	localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int HW     = $clog2(NWORDS + 1);
	localparam int CW     = $clog2(PAGE_COUNT + 1);
	localparam int REM    = PAGE_COUNT - WORD_W * (NWORDS - 1);
	localparam logic [WORD_W-1:0] LAST_MASK =
		(REM == WORD_W) ? {WORD_W{1'b1}} : WORD_W'((64'd1 << REM) - 64'd1);

	logic [WORD_W-1:0] mem [NWORDS];

	logic [HW-1:0]         hint_q;
	logic [HW-1:0]         ptr_q;
	logic [CW-1:0]         used_q;
	logic [AW-1:0]         clr_cnt_q;
	logic [ADDR_W-1:0]     faddr_q;
	logic [WORD_W-1:0]     rdata_q;
	logic [WORD_SHIFT-1:0] bitpos_q;
	logic [ADDR_W-1:0]     addr_q;
	status_t               status_q;

	logic [ADDR_W-1:0]     offset;
	logic [PIDX_W-1:0]     pg;
	logic                  in_range;
	logic                  aligned;
	logic [AW-1:0]         fw;
	logic [WORD_SHIFT-1:0] fb;
	status_t               free_code;
	logic [AW-1:0]         rd_addr;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [WORD_W-1:0]     wr_data;
	logic                  ptr_last;
	logic [WORD_W-1:0]     free_bits;
	logic [WORD_SHIFT-1:0] first;

	// free request checks, region first, then alignment
	assign offset    = faddr_q - base_page;
	assign pg        = offset[ADDR_W-1:PAGE_SHIFT];
	assign in_range  = pg < PIDX_W'(PAGE_COUNT);
	assign aligned   = faddr_q[PAGE_SHIFT-1:0] == '0;
	assign fw        = pg[WORD_SHIFT +: AW];
	assign fb        = pg[WORD_SHIFT-1:0];
	assign free_code = !in_range ? ST_OUTSIDE : (!aligned ? ST_MISALIGNED : ST_OK);

	always_comb begin
		case (cmd.rd_sel)
			RD_HINT: rd_addr = hint_q[AW-1:0];
			RD_PTR:  rd_addr = ptr_q[AW-1:0];
			RD_FREE: rd_addr = fw;
			default: rd_addr = ptr_q[AW-1:0];
		endcase
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = clr_cnt_q;
		wr_data = '0;
		if (cmd.clr_wr) begin
			wr_en = 1'b1;
		end else if (cmd.alloc_wr) begin
			wr_en   = 1'b1;
			wr_addr = ptr_q[AW-1:0];
			wr_data = rdata_q | (WORD_W'(1) << bitpos_q);
		end else if (cmd.free_wr) begin
			wr_en   = 1'b1;
			wr_addr = fw;
			wr_data = rdata_q & ~(WORD_W'(1) << fb);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// pad bits past the last page read as used
	assign ptr_last  = ptr_q == HW'(NWORDS - 1);
	assign free_bits = ~rdata_q & (ptr_last ? LAST_MASK : {WORD_W{1'b1}});

	always_comb begin
		first = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (free_bits[i]) begin
				first = WORD_SHIFT'(i);
			end
		end
	end

	assign stat.clr_last = clr_cnt_q == AW'(NWORDS - 1);
	assign stat.at_end   = ptr_q == HW'(NWORDS);
	assign stat.has_free = |free_bits;
	assign stat.free_ok  = free_code == ST_OK;
	assign stat.bit_used = rdata_q[fb];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hint_q    <= '0;
			used_q    <= '0;
			clr_cnt_q <= '0;
		end else begin
			if (cmd.clr_wr) begin
				hint_q    <= '0;
				used_q    <= '0;
				clr_cnt_q <= stat.clr_last ? '0 : clr_cnt_q + 1'b1;
			end
			if (cmd.alloc_full) begin
				hint_q <= HW'(NWORDS);
			end
			if (cmd.alloc_wr) begin
				hint_q <= ptr_q;
				used_q <= used_q + 1'b1;
			end
			if (cmd.free_wr) begin
				used_q <= used_q - 1'b1;
				if (HW'(fw) < hint_q) begin
					hint_q <= HW'(fw);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			faddr_q  <= free_address;
			ptr_q    <= hint_q;
			addr_q   <= '0;
			status_q <= ST_OK;
		end
		if (cmd.ptr_inc) begin
			ptr_q <= ptr_q + 1'b1;
		end
		if (cmd.alloc_take) begin
			bitpos_q <= first;
		end
		if (cmd.alloc_full) begin
			status_q <= ST_FULL;
		end
		if (cmd.alloc_wr) begin
			addr_q <= base_page +
				(ADDR_W'({ptr_q[AW-1:0], bitpos_q}) << PAGE_SHIFT);
		end
		if (cmd.free_fail) begin
			status_q <= free_code;
		end
		if (cmd.free_miss) begin
			status_q <= ST_NOT_USED;
		end
	end

	assign page_address = addr_q;
	assign status       = status_q;
	assign used_count   = CNT_W'(used_q);
	assign free_count   = CNT_W'(CW'(PAGE_COUNT) - used_q);

endmodule

// File: rtl/bitmap_page_allocator.sv
// First-fit page frame allocator over PAGE_COUNT pages of 4 KiB starting at
// region_base (low twelve bits ignored). The page map is held one bit per
// page in a memory of 32-bit words; a hint pointer marks the lowest word that
// may still hold a free page, so allocate starts its search there. Each
// transaction on the input stream is one request (clear, allocate or free)
// and produces exactly one result transaction with the page address, a
// status code and the used and free page counts after the request. The
// block works on one request at a time; the result sits in an output
// register, so the next request is taken while the previous result waits.
// Allocate reads the word at the hint on acceptance, checks it, and while the
// word holds no free page reads and checks the next one; it writes the word
// back with the bit set when it finds a free page, and reports full once it
// has stepped past the last word. Free checks region and alignment and, if
// both pass, reads the word and clears the bit or reports a page not in use;
// the unused op code goes straight to the result; clear sweeps the map one word per cycle.
// After reset the same sweep runs with s_tready low; configuration writes are
// taken at any time and must only happen while no request is in flight.
module bitmap_page_allocator import bpa_pkg::*; #(
	parameter int PAGE_COUNT = 3584
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write: region_base
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] free_address
	input  logic [1:0]  s_tuser,   // [1:0] op
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata    // [31:0] page_address, [34:32] status,
	                               // [46:35] used_count, [58:47] free_count
);

	logic [ADDR_W-1:0] base_q;
	logic [ADDR_W-1:0] base_page;
	logic              m_tvalid_q;
	logic [63:0]       m_tdata_q;
	logic              out_busy;
	cmd_t              cmd;
	dp_stat_t          stat;
	logic [ADDR_W-1:0] page_address;
	status_t           status;
	logic [CNT_W-1:0]  used_count;
	logic [CNT_W-1:0]  free_count;

	// region base register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= 32'h0020_0000;
		end else if (cfg_valid) begin
			base_q <= cfg_data;
		end
	end

	assign base_page = {base_q[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};

	// hold the result until the sink takes it
	assign out_busy = m_tvalid_q && !m_tready;

	bpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.op       (op_t'(s_tuser)),
		.out_busy (out_busy),
		.stat     (stat),
		.in_ready (s_tready),
		.cmd      (cmd)
	);

	bpa_dp #(
		.PAGE_COUNT (PAGE_COUNT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.base_page    (base_page),
		.free_address (s_tdata),
		.stat         (stat),
		.page_address (page_address),
		.status       (status),
		.used_count   (used_count),
		.free_count   (free_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			m_tdata_q <= {5'b0, free_count, used_count, status, page_address};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
